>>> hdl/rpn_pkg.sv
// Package for the RPN stack calculator: request codes, status codes, types.
package rpn_pkg;

  localparam int StackDepthDef = 32;
  localparam int DataWidthDef  = 32;
  localparam int ReqW          = 4;
  localparam int StatusW       = 2;
  localparam int ResultW       = 32;
  localparam int QueueDepth    = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH  = 4'd0,
    REQ_ADD   = 4'd1,
    REQ_SUB   = 4'd2,
    REQ_MUL   = 4'd3,
    REQ_DIV   = 4'd4,
    REQ_SWAP  = 4'd5,
    REQ_NEG   = 4'd6,
    REQ_DUP   = 4'd7,
    REQ_PRINT = 4'd8,
    REQ_CLEAR = 4'd9,
    REQ_PALL  = 4'd10
  } req_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_NEG,
    OP_DUP, OP_PRINT, OP_CLEAR, OP_PALL, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR2, S_PREAD, S_PEMIT, S_OUT
  } state_t;

endpackage

>>> hdl/rpn_front.sv
// Front end: accepts requests, classifies them and queues them for execution.
module rpn_front
  import rpn_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ReqW-1:0]       in_req,
  input  logic [31:0]           in_value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output op_t                   q_op,
  output logic [DATA_WIDTH-1:0] q_value
);

  localparam int PtrW = $clog2(QueueDepth);

  op_t                   op_mem [QueueDepth];
  logic [DATA_WIDTH-1:0] val_mem [QueueDepth];
  logic [PtrW-1:0]       wp_r, rp_r;
  logic [PtrW:0]         cnt_r;
  op_t                   cls;
  logic [DATA_WIDTH-1:0] ext;
  logic                  push, pop;

  always_comb begin
    case (in_req)
      REQ_PUSH:  cls = OP_PUSH;
      REQ_ADD:   cls = OP_ADD;
      REQ_SUB:   cls = OP_SUB;
      REQ_MUL:   cls = OP_MUL;
      REQ_DIV:   cls = OP_DIV;
      REQ_SWAP:  cls = OP_SWAP;
      REQ_NEG:   cls = OP_NEG;
      REQ_DUP:   cls = OP_DUP;
      REQ_PRINT: cls = OP_PRINT;
      REQ_CLEAR: cls = OP_CLEAR;
      REQ_PALL:  cls = OP_PALL;
      default:   cls = OP_NOP;
    endcase
  end

  generate
    if (DATA_WIDTH > 32) begin : g_wide
      assign ext = {{(DATA_WIDTH-32){in_value[31]}}, in_value};
    end else begin : g_narrow
      assign ext = in_value[DATA_WIDTH-1:0];
    end
  endgenerate

  assign in_ready = (cnt_r < (PtrW+1)'(QueueDepth));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_op     = op_mem[rp_r];
  assign q_value  = val_mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wp_r]  <= cls;
      val_mem[wp_r] <= ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("queue push lost");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

>>> hdl/rpn_divider.sv
// Iterative restoring divider, one quotient bit per cycle, truncating signed.
module rpn_divider
  import rpn_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int CntW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] q_r, d_r;
  logic [DATA_WIDTH:0]   rem_r;
  logic [CntW-1:0]       cnt_r;
  logic                  busy_r, neg_r, done_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] ma, mb;

  assign ma    = dividend[DATA_WIDTH-1] ? -dividend : dividend;
  assign mb    = divisor[DATA_WIDTH-1] ? -divisor : divisor;
  assign trial = {rem_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]} - {1'b0, d_r};
  assign done     = done_r;
  assign quotient = neg_r ? -q_r : q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= ma;
      d_r   <= mb;
      rem_r <= '0;
      neg_r <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
    end else if (busy_r) begin
      if (!trial[DATA_WIDTH]) begin
        rem_r <= trial;
        q_r   <= {q_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_WIDTH-1:0], q_r[DATA_WIDTH-1]};
        q_r   <= {q_r[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/rpn_back.sv
// Back end: stack memory, execution sequencer and result register.
module rpn_back
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int DATA_WIDTH  = DataWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  op_t                   q_op,
  input  logic [DATA_WIDTH-1:0] q_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [StatusW-1:0]    out_status,
  output logic                  out_has,
  output logic [ResultW-1:0]    out_value,
  output logic                  out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_r, a_r, b_r;
  logic [AW-1:0]         ra, wa;
  logic                  we;
  logic [DATA_WIDTH-1:0] wd;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic [2*DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] res;
  logic div_start, div_done;
  logic [DATA_WIDTH-1:0] quo;

  logic [StatusW-1:0] st_r, st_nxt;
  logic has_r, has_nxt;
  logic [DATA_WIDTH-1:0] ov_r, ov_nxt;
  logic a_ld, b_ld;
  // a_done_r marks that both operands were loaded for this request
  logic a_done_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // the lower operand is on the read port in the cycle the divide starts
  rpn_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rd_r), .divisor(b_r),
    .done(div_done), .quotient(quo));

  assign prod = a_r * b_r;

  always_comb begin
    case (op_r)
      OP_ADD:  res = a_r + b_r;
      OP_SUB:  res = a_r - b_r;
      OP_MUL:  res = prod[DATA_WIDTH-1:0];
      default: res = quo;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_RD1;
      S_RD1: begin
        case (op_r)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP:
            state_nxt = (n_r < CW'(2)) ? S_OUT : S_RD2;
          OP_NEG, OP_DUP, OP_PRINT:
            state_nxt = (n_r == '0) ? S_OUT : S_RD2;
          OP_PALL: state_nxt = (n_r == '0) ? S_OUT : S_PREAD;
          default: state_nxt = S_OUT;
        endcase
      end
      S_RD2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_DIV && b_r != '0) state_nxt = S_DIV;
        else if (op_r == OP_SWAP) state_nxt = S_WR2;
        else state_nxt = S_OUT;
      end
      S_DIV: if (div_done) state_nxt = S_OUT;
      S_WR2: state_nxt = S_OUT;
      S_PREAD: state_nxt = S_PEMIT;
      S_PEMIT: if (!out_valid || out_ready)
        state_nxt = (k_r == CW'(1)) ? S_IDLE : S_PREAD;
      S_OUT: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_ready = 1'b0; we = 1'b0; wa = '0; wd = '0; ra = '0;
    a_ld = 1'b0; b_ld = 1'b0;
    n_nxt = n_r; k_nxt = k_r;
    st_nxt = st_r; has_nxt = has_r; ov_nxt = ov_r;
    case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        st_nxt = ST_OK; has_nxt = 1'b0; ov_nxt = '0;
      end
      S_RD1: begin
        ra = AW'(n_r - CW'(1));
        case (op_r)
          OP_PUSH: begin
            if (n_r == CW'(STACK_DEPTH)) st_nxt = ST_FULL;
            else begin
              we = 1'b1; wa = AW'(n_r); wd = val_r; n_nxt = n_r + 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP:
            if (n_r < CW'(2)) st_nxt = ST_FEW;
          OP_NEG, OP_DUP, OP_PRINT:
            if (n_r == '0) st_nxt = ST_FEW;
          OP_CLEAR: n_nxt = '0;
          OP_PALL: k_nxt = n_r;
          default: ;
        endcase
      end
      S_RD2: begin
        ra = AW'(n_r - CW'(2));
        b_ld = 1'b1;
      end
      S_EXEC: begin
        a_ld = 1'b1;
        case (op_r)
          OP_NEG: begin
            we = 1'b1; wa = AW'(n_r - CW'(1)); wd = -b_r;
          end
          OP_DUP: begin
            if (n_r == CW'(STACK_DEPTH)) st_nxt = ST_FULL;
            else begin
              we = 1'b1; wa = AW'(n_r); wd = b_r; n_nxt = n_r + 1'b1;
            end
          end
          OP_PRINT: begin
            has_nxt = 1'b1; ov_nxt = b_r;
          end
          OP_DIV: begin
            if (b_r == '0) st_nxt = ST_DIV0;
          end
          OP_SWAP: begin
            we = 1'b1; wa = AW'(n_r - CW'(1)); wd = rd_r;
          end
          default: ;
        endcase
      end
      S_DIV: ;
      S_WR2: begin
        we = 1'b1; wa = AW'(n_r - CW'(2)); wd = b_r;
      end
      S_PREAD: ra = AW'(k_r - CW'(1));
      S_PEMIT: begin
        ra = AW'(k_r - CW'(1));
        if (!out_valid || out_ready) k_nxt = k_r - 1'b1;
      end
      S_OUT: ;
      default: ;
    endcase
    // arithmetic write-back at the last step before the result
    if (state_r == S_OUT && (op_r == OP_ADD || op_r == OP_SUB ||
        op_r == OP_MUL || op_r == OP_DIV) && st_r == ST_OK && n_r >= CW'(2)
        && (!out_valid || out_ready) && a_done_r) begin
      we = 1'b1; wa = AW'(n_r - CW'(2)); wd = res; n_nxt = n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      op_r  <= q_op;
      val_r <= q_value;
    end
    if (b_ld) b_r <= rd_r;
    if (a_ld) a_r <= rd_r;
    st_r <= st_nxt; has_r <= has_nxt; ov_r <= ov_nxt;
  end

  assign div_start = (state_r == S_EXEC) && (op_r == OP_DIV) && (b_r != '0);

  logic ovalid_r, olast_r, ohas_r;
  logic [StatusW-1:0] ost_r;
  logic [DATA_WIDTH-1:0] oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      n_r      <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
      a_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      if (state_r == S_IDLE) a_done_r <= 1'b0;
      else if (a_ld) a_done_r <= 1'b1;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if ((state_r == S_OUT || state_r == S_PEMIT) && (!out_valid || out_ready))
        ovalid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT || state_r == S_PEMIT) && (!out_valid || out_ready)) begin
      if (state_r == S_PEMIT) begin
        ost_r <= ST_OK; ohas_r <= 1'b1; oval_r <= rd_r;
        olast_r <= (k_r == CW'(1));
      end else begin
        ost_r <= st_r; ohas_r <= has_r; oval_r <= ov_r; olast_r <= 1'b1;
      end
    end
  end

  generate
    if (DATA_WIDTH >= ResultW) begin : g_ow
      assign out_value = ohas_r ? oval_r[ResultW-1:0] : '0;
    end else begin : g_on
      assign out_value = ohas_r ?
        {{(ResultW-DATA_WIDTH){oval_r[DATA_WIDTH-1]}}, oval_r} : '0;
    end
  endgenerate

  assign out_valid  = ovalid_r;
  assign out_status = ost_r;
  assign out_has    = ohas_r;
  assign out_last   = olast_r;

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> (state_r == S_IDLE)) else $error("request taken while busy");
  a_pall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEMIT) |-> (k_r != '0)) else $error("print-all walk underrun");
`endif

endmodule

>>> hdl/rpn_stack_calculator_core.sv
// Top level of the RPN stack calculator: front queue and back-end executor.
//
//  channel  dir  tdata fields (low bit up)                    tuser / tlast
//  in_      in   req_type[3:0], push_value[35:4], pad          -
//  out_     out  status[1:0], result_value[33:2], pad          has_value / last
//
// Push, clear, unused codes and too-few-operand failures go from the first read
// state to output; add/sub/mul/neg/dup/print and divide by zero also pass the
// second read and execute states, swap a write state too; divide waits on the
// one-bit-per-cycle divider; print all reads, then emits, each entry in turn.
// Reset empties the stack; entry contents are not cleared.
// A stalled output holds the executor while requests fill the two-entry queue.
module rpn_stack_calculator_core
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int DATA_WIDTH  = DataWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // req_type[3:0], push_value[35:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], result_value[33:2]
  output logic        out_tuser,  // has_value
  output logic        out_tlast   // last
);

  logic                  q_valid, q_ready;
  op_t                   q_op;
  logic [DATA_WIDTH-1:0] q_value;
  logic [StatusW-1:0]    st;
  logic [ResultW-1:0]    val;

  rpn_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_req(in_tdata[3:0]), .in_value(in_tdata[35:4]),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_value(q_value));

  rpn_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_op(q_op), .q_value(q_value), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_status(st), .out_has(out_tuser),
    .out_value(val), .out_last(out_tlast));

  assign out_tdata = {6'd0, val, st};

endmodule

>>> sim/tb_rpn_stack_calculator_core.sv
// Testbench for the RPN stack calculator core: directed and random request streams.
module tb_rpn_stack_calculator_core;
  import rpn_pkg::*;

  localparam int Depth    = StackDepthDef;
  localparam int MaxCycle = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_value;
    logic [31:0] value;
    logic        last;
  } calc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  calc_result_t expected_results[$];
  logic [31:0]  stack_mdl[Depth];
  int           stack_depth_mdl;
  int           errors;
  int           n_results;
  int           n_requests;
  int           cycles;
  bit           rx_hold;

  rpn_stack_calculator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic calc_result_t mk_result(logic [1:0] st, logic has, logic [31:0] v,
                                             logic lst);
    calc_result_t r;
    r.status    = st;
    r.has_value = has;
    r.value     = has ? v : 32'd0;
    r.last      = lst;
    return r;
  endfunction

  // Apply one request to the model stack and queue its results
  task automatic predict_request(logic [3:0] req, logic [31:0] pv);
    int          n;
    logic [31:0] a, b, q, ma, mb;
    logic [1:0]  st;
    logic        has;
    logic [31:0] v;
    n   = stack_depth_mdl;
    st  = ST_OK;
    has = 1'b0;
    v   = '0;
    case (req)
      REQ_PUSH: begin
        if (n >= Depth) st = ST_FULL;
        else begin
          stack_mdl[n] = pv;
          stack_depth_mdl = n + 1;
        end
      end
      REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_SWAP: begin
        if (n < 2) st = ST_FEW;
        else begin
          a = stack_mdl[n-2];
          b = stack_mdl[n-1];
          if (req == REQ_DIV && b == 0) st = ST_DIV0;
          else if (req == REQ_SWAP) begin
            stack_mdl[n-2] = b;
            stack_mdl[n-1] = a;
          end else begin
            case (req)
              REQ_ADD: q = a + b;
              REQ_SUB: q = a - b;
              REQ_MUL: q = a * b;
              default: begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q  = ma / mb;
                if (a[31] != b[31]) q = -q;
              end
            endcase
            stack_mdl[n-2] = q;
            stack_depth_mdl = n - 1;
          end
        end
      end
      REQ_NEG, REQ_DUP, REQ_PRINT: begin
        if (n == 0) st = ST_FEW;
        else if (req == REQ_NEG) stack_mdl[n-1] = -stack_mdl[n-1];
        else if (req == REQ_DUP) begin
          if (n >= Depth) st = ST_FULL;
          else begin
            stack_mdl[n] = stack_mdl[n-1];
            stack_depth_mdl = n + 1;
          end
        end else begin
          has = 1'b1;
          v   = stack_mdl[n-1];
        end
      end
      REQ_CLEAR: stack_depth_mdl = 0;
      REQ_PALL: begin
        if (n > 0) begin
          for (int k = 0; k < n; k++)
            expected_results.push_back(mk_result(ST_OK, 1'b1, stack_mdl[n-1-k], k == n-1));
          return;
        end
      end
      default: ;
    endcase
    expected_results.push_back(mk_result(st, has, v, 1'b1));
  endtask

  // Returns at the accepting edge; a later gap or wait_drained takes tvalid down
  task automatic send_request(logic [3:0] req, logic [31:0] pv = 32'd0, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 40'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, pv, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(req, pv);
    n_requests++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= 40'({$urandom, $urandom});
    while (expected_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Receiver: random stalls per result, long hold-off when requested
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) out_tready <= 1'b0;
      else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!(out_tvalid && out_tready)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    calc_result_t exp_r, act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = mk_result(out_tdata[1:0], out_tuser, out_tdata[33:2], out_tlast);
      act_r.value = out_tdata[33:2];
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, act_r);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (act_r.status != exp_r.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, act_r.status);
          errors++;
        end
        if (act_r.has_value != exp_r.has_value) begin
          $display("%0t has_value: expected %0d actual %0d", $time, exp_r.has_value,
                   act_r.has_value);
          errors++;
        end
        if (act_r.value != exp_r.value) begin
          $display("%0t value: expected %h actual %h", $time, exp_r.value, act_r.value);
          errors++;
        end
        if (act_r.last != exp_r.last) begin
          $display("%0t last: expected %0d actual %0d", $time, exp_r.last, act_r.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycle) begin
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_empty_stack();
    send_request(REQ_ADD);
    send_request(REQ_DIV);
    send_request(REQ_SWAP);
    send_request(REQ_NEG);
    send_request(REQ_DUP);
    send_request(REQ_PRINT);
    send_request(REQ_PALL);
    send_request(4'd11);
    send_request(4'd15, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'd5);
    send_request(REQ_SUB);
  endtask

  task automatic test_arith_corners();
    send_request(REQ_CLEAR);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_DIV);
    send_request(REQ_PRINT);
    send_request(REQ_PUSH, 32'h7fff_ffff);
    send_request(REQ_ADD);
    send_request(REQ_PUSH, 32'd0);
    send_request(REQ_DIV);
    send_request(REQ_PUSH, -32'sd7);
    send_request(REQ_DIV);
    send_request(REQ_PUSH, 32'd3);
    send_request(REQ_MUL);
    send_request(REQ_NEG);
    send_request(REQ_SWAP);
    send_request(REQ_PALL);
  endtask

  task automatic test_full_stack();
    send_request(REQ_CLEAR);
    for (int i = 0; i < Depth; i++) send_request(REQ_PUSH, $urandom);
    send_request(REQ_PUSH, 32'd1);
    send_request(REQ_DUP);
    send_request(REQ_PALL);
    wait_drained();
  endtask

  // Receiver blocks while requests keep coming, so the input queue fills
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(i % 2 ? REQ_PRINT : REQ_PUSH, $urandom, 1);
    join
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [3:0] req;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) req = REQ_PUSH;
      else if (pick < 80) req = 4'($urandom_range(REQ_ADD, REQ_PRINT));
      else if (pick < 86) req = REQ_PALL;
      else if (pick < 89) req = REQ_CLEAR;
      else if (pick < 92) req = 4'($urandom_range(11, 15));
      else req = REQ_DIV;
      case ($urandom_range(0, 4))
        0: send_request(req, $urandom_range(0, 3) - 1);
        1: send_request(req, {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)});
        default: send_request(req, $urandom);
      endcase
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    rx_hold    = 1'b0;
    errors     = 0;
    n_results  = 0;
    n_requests = 0;
    cycles     = 0;
    stack_depth_mdl = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_empty_stack();
    test_arith_corners();
    test_full_stack();
    test_backpressure();
    test_random(300);
    wait_drained();
    if (expected_results.size() != 0) errors++;
    $display("covered %0d requests and %0d results: all operations, errors, full stack,",
             n_requests, n_results);
    $display("divide corners, print-all walks and long output stalls");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
hdl/rpn_pkg.sv
hdl/rpn_front.sv
hdl/rpn_divider.sv
hdl/rpn_back.sv
hdl/rpn_stack_calculator_core.sv
sim/tb_rpn_stack_calculator_core.sv
